### sv/srt_pkg.sv
`timescale 1ns / 1ps

package srt_pkg;

  // Table geometry.
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed widths of the result fields.
  localparam int POS_W    = 6;
  localparam int ECNT_W   = 7;

  localparam int KEY_W    = 32;
  localparam int ROOM_W   = 16;
  localparam int ENTRY_W  = KEY_W + ROOM_W;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Operation codes.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]        op;
    logic [KEY_W-1:0]  student_id;
    logic [ROOM_W-1:0] room_number;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ROOM_W-1:0] room_out;
    logic [POS_W-1:0]  position;
    logic [ECNT_W-1:0] entry_count;
  } out_t;

endpackage

### sv/sorted_record_table_top.sv
`timescale 1ns / 1ps
// Insert moves every entry above the new key up by one slot, delete scans every entry,
// lookup is a binary search; a full table or an unknown operation goes straight to the output.
// Throughput: one request at a time; the next is taken only after the current one has
// searched the table RAM (one write port, one registered read port) and reached the output.
// Reset: synchronous active-low rst_n clears the sequencer, the record count and the
// output valid; the table RAM is not cleared, only entries below the count are ever read.

module sorted_record_table_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  srt_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output srt_pkg::out_t out_data
);

  localparam int AW = srt_pkg::ADDR_W;
  localparam int CW = srt_pkg::CNT_W;
  localparam int SW = srt_pkg::CNT_W + 1;

  localparam logic signed [SW-1:0] ONE_S = SW'(1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS_RD  = 3'd1;
  localparam logic [2:0] S_INS_CMP = 3'd2;
  localparam logic [2:0] S_DEL_RD  = 3'd3;
  localparam logic [2:0] S_DEL_CMP = 3'd4;
  localparam logic [2:0] S_LK_RD   = 3'd5;
  localparam logic [2:0] S_LK_CMP  = 3'd6;
  localparam logic [2:0] S_OUT     = 3'd7;

  logic [2:0]               state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  srt_pkg::in_t             req_r, req_nxt;
  logic [CW-1:0]            idx_r, idx_nxt;
  logic                     found_r, found_nxt;
  logic [AW-1:0]            pos_r, pos_nxt;
  logic signed [SW-1:0]     lo_r, lo_nxt;
  logic signed [SW-1:0]     hi_r, hi_nxt;
  logic [AW-1:0]            mid_r, mid_nxt;
  logic [1:0]               status_r, status_nxt;
  logic [srt_pkg::ROOM_W-1:0] room_r, room_nxt;
  logic                     out_valid_r, out_valid_nxt;
  srt_pkg::out_t            out_data_r, out_data_nxt;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [srt_pkg::ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]              ram_raddr;
  logic [srt_pkg::ENTRY_W-1:0] ram_rdata;

  logic [srt_pkg::KEY_W-1:0]  rd_key;
  logic [srt_pkg::ENTRY_W-1:0] new_entry;
  logic [CW-1:0]              idx_m1;
  logic [CW-1:0]              count_m1;
  logic signed [SW:0]         lohi_sum;
  logic                       key_match;

  srt_ram #(
    .WIDTH(srt_pkg::ENTRY_W),
    .DEPTH(srt_pkg::CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // The identifier sits in the upper bits of a stored entry, the room in the lower.
  assign rd_key    = ram_rdata[srt_pkg::ENTRY_W-1:srt_pkg::ROOM_W];
  assign new_entry = {req_r.student_id, req_r.room_number};
  assign idx_m1    = idx_r - CW'(1);
  assign count_m1  = count_r - CW'(1);
  assign lohi_sum  = {lo_r[SW-1], lo_r} + {hi_r[SW-1], hi_r};
  assign key_match = (rd_key == req_r.student_id);

  // A new request is taken whenever the sequencer is idle; a result still waiting at the
  // output does not block it, the result stage only waits before loading the next one.
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    req_nxt       = req_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    pos_nxt       = pos_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    status_nxt    = status_r;
    room_nxt      = room_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r[AW-1:0];
    ram_wdata     = new_entry;
    ram_raddr     = idx_r[AW-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_data;
          status_nxt = srt_pkg::ST_NOT_FOUND;
          room_nxt   = '0;
          pos_nxt    = '0;
          found_nxt  = 1'b0;
          unique case (in_data.op)
            srt_pkg::OP_INSERT: begin
              if (count_r >= srt_pkg::CAP_CNT) begin
                status_nxt = srt_pkg::ST_FULL;
                state_nxt  = S_OUT;
              end else begin
                // Walk down from the top, moving larger keys up by one slot.
                idx_nxt   = count_r;
                state_nxt = S_INS_RD;
              end
            end
            srt_pkg::OP_DELETE: begin
              idx_nxt   = '0;
              state_nxt = (count_r == '0) ? S_OUT : S_DEL_RD;
            end
            srt_pkg::OP_LOOKUP: begin
              lo_nxt    = '0;
              hi_nxt    = $signed({1'b0, count_r}) - ONE_S;
              state_nxt = S_LK_RD;
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end

      S_INS_RD: begin
        if (idx_r == '0) begin
          ram_we     = 1'b1;
          ram_waddr  = '0;
          count_nxt  = count_r + CW'(1);
          status_nxt = srt_pkg::ST_OK;
          pos_nxt    = '0;
          state_nxt  = S_OUT;
        end else begin
          ram_raddr = idx_m1[AW-1:0];
          state_nxt = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        ram_we = 1'b1;
        if (req_r.student_id < rd_key) begin
          ram_wdata = ram_rdata;
          idx_nxt   = idx_m1;
          state_nxt = S_INS_RD;
        end else begin
          count_nxt  = count_r + CW'(1);
          status_nxt = srt_pkg::ST_OK;
          pos_nxt    = idx_r[AW-1:0];
          state_nxt  = S_OUT;
        end
      end

      S_DEL_RD: begin
        state_nxt = S_DEL_CMP;
      end

      S_DEL_CMP: begin
        // Once the first match is seen, every later entry moves down by one slot.
        if (found_r) begin
          ram_we    = 1'b1;
          ram_waddr = idx_m1[AW-1:0];
          ram_wdata = ram_rdata;
        end else if (key_match) begin
          found_nxt = 1'b1;
          pos_nxt   = idx_r[AW-1:0];
        end
        if (idx_r == count_m1) begin
          if (found_r || key_match) begin
            count_nxt  = count_m1;
            status_nxt = srt_pkg::ST_OK;
          end
          state_nxt = S_OUT;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_DEL_RD;
        end
      end

      S_LK_RD: begin
        if (lo_r > hi_r) begin
          state_nxt = S_OUT;
        end else begin
          mid_nxt   = lohi_sum[AW:1];
          ram_raddr = lohi_sum[AW:1];
          state_nxt = S_LK_CMP;
        end
      end

      S_LK_CMP: begin
        if (key_match) begin
          status_nxt = srt_pkg::ST_OK;
          room_nxt   = ram_rdata[srt_pkg::ROOM_W-1:0];
          pos_nxt    = mid_r;
          state_nxt  = S_OUT;
        end else begin
          if (req_r.student_id > rd_key) begin
            lo_nxt = $signed({{(SW-AW){1'b0}}, mid_r}) + ONE_S;
          end else begin
            hi_nxt = $signed({{(SW-AW){1'b0}}, mid_r}) - ONE_S;
          end
          state_nxt = S_LK_RD;
        end
      end

      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = status_r;
          out_data_nxt.room_out    = room_r;
          out_data_nxt.position    = (srt_pkg::POS_W)'(pos_r);
          out_data_nxt.entry_count = (srt_pkg::ECNT_W)'(count_r);
          state_nxt                = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    idx_r      <= idx_nxt;
    found_r    <= found_nxt;
    pos_r      <= pos_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    status_r   <= status_nxt;
    room_r     <= room_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sv/srt_ram.sv
`timescale 1ns / 1ps

module srt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
